/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// antecedent holds -> consequent holds in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication failed");
// antecedent holds -> consequent holds in the following cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* sv/tequ_pkg.sv */
// ----------------------------------------------------------------------------
// tequ_pkg
// Shared constants, codes and control/status types of the timed event queue.
// ----------------------------------------------------------------------------
`default_nettype none

package tequ_pkg;

   localparam int QUEUE_DEPTH = 32;
   localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int MAX_POPS    = 32;
   localparam int CNT_W       = 6;
   localparam int TIME_W      = 32;
   localparam int HANDLE_W    = 16;
   localparam int OP_W        = 2;
   localparam int STATUS_W    = 3;

   localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
   localparam logic [OP_W-1:0] OP_ADVANCE = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DUE      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NONE     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_SKIPPED  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd5;

   // commands from the controller to the datapath
   typedef struct packed {
      logic                load;
      logic                do_insert;
      logic                do_clear;
      logic                do_add;
      logic                do_pop;
      logic                emit;
      logic [STATUS_W-1:0] emit_status;
      logic                emit_last;
   } ctrl_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            skip;
      logic            full;
      logic            head_due;
      logic            next_due;
   } stat_type;

endpackage

`default_nettype wire

/* sv/tequ_datapath.sv */
// ----------------------------------------------------------------------------
// tequ_datapath
// Request registers, sorted shift-register queue, running time, pop counter
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tequ_datapath (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic [tequ_pkg::OP_W-1:0]        req_operation,
   input  wire logic [tequ_pkg::HANDLE_W-1:0]    req_op_handle,
   input  wire logic [tequ_pkg::TIME_W-1:0]      req_time_value,
   input  wire logic                             req_skip,
   input  wire tequ_pkg::ctrl_type               ctrl,
   output tequ_pkg::stat_type                    stat,
   output logic                                  rsp_strobe,
   output logic [tequ_pkg::STATUS_W-1:0]         rsp_status,
   output logic [tequ_pkg::HANDLE_W-1:0]         rsp_event_handle,
   output logic [tequ_pkg::TIME_W-1:0]           rsp_lateness,
   output logic [tequ_pkg::CNT_W-1:0]            rsp_removed_count,
   output logic                                  rsp_last
);
   import tequ_pkg::*;

   logic [OP_W-1:0]     op_ff;
   logic [HANDLE_W-1:0] hreq_ff;
   logic [TIME_W-1:0]   tv_ff;
   logic                skip_ff;

   logic [TIME_W-1:0]   due_ff [QUEUE_DEPTH];
   logic [TIME_W-1:0]   due_in [QUEUE_DEPTH];
   logic [HANDLE_W-1:0] hnd_ff [QUEUE_DEPTH];
   logic [HANDLE_W-1:0] hnd_in [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] gt;

   logic [OCC_W-1:0]  occ_ff,  occ_in;
   logic [TIME_W-1:0] rt_ff,   rt_in;
   logic [CNT_W-1:0]  rem_ff,  rem_in;

   logic                strobe_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [HANDLE_W-1:0] ehnd_ff;
   logic [TIME_W-1:0]   late_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic                last_ff;

   // insert position: entries with an earlier due time form a prefix
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         gt[i] = (OCC_W'(i) < occ_ff) && (tv_ff > due_ff[i]);
      end
   end

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         due_in[i] = due_ff[i];
         hnd_in[i] = hnd_ff[i];
         if (ctrl.do_insert) begin
            if (!gt[i]) begin
               if (i == 0 || gt[(i == 0) ? 0 : i - 1]) begin
                  due_in[i] = tv_ff;
                  hnd_in[i] = hreq_ff;
               end else begin
                  due_in[i] = due_ff[(i == 0) ? 0 : i - 1];
                  hnd_in[i] = hnd_ff[(i == 0) ? 0 : i - 1];
               end
            end
         end else if (ctrl.do_pop && i < QUEUE_DEPTH - 1) begin
            due_in[i] = due_ff[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
            hnd_in[i] = hnd_ff[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
         end
      end
   end

   always_comb begin
      occ_in = occ_ff;
      rt_in  = rt_ff;
      rem_in = rem_ff;
      if (ctrl.do_clear) begin
         occ_in = '0;
         rt_in  = '0;
      end else if (ctrl.do_insert) begin
         occ_in = occ_ff + OCC_W'(1);
      end else if (ctrl.do_pop) begin
         occ_in = occ_ff - OCC_W'(1);
         rem_in = rem_ff + CNT_W'(1);
      end
      if (ctrl.do_add) begin
         rt_in = rt_ff + tv_ff;
      end
      if (ctrl.load) begin
         rem_in = '0;
      end
   end

   always_comb begin
      stat.op       = op_ff;
      stat.skip     = skip_ff;
      stat.full     = (occ_ff == OCC_W'(QUEUE_DEPTH));
      stat.head_due = (occ_ff != '0) && (due_ff[0] <= rt_ff)
                      && (rem_ff < CNT_W'(MAX_POPS));
      stat.next_due = (occ_ff > OCC_W'(1)) && (due_ff[1] <= rt_ff)
                      && (rem_ff < CNT_W'(MAX_POPS - 1));
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         op_ff   <= req_operation;
         hreq_ff <= req_op_handle;
         tv_ff   <= req_time_value;
         skip_ff <= req_skip;
      end
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         due_ff[i] <= due_in[i];
         hnd_ff[i] <= hnd_in[i];
      end
      rem_ff <= rem_in;
      if (ctrl.emit) begin
         status_ff <= ctrl.emit_status;
         last_ff   <= ctrl.emit_last;
         ehnd_ff   <= (ctrl.emit_status == ST_DUE) ? hnd_ff[0] : '0;
         late_ff   <= (ctrl.emit_status == ST_DUE) ? (rt_ff - due_ff[0]) : '0;
         cnt_ff    <= (ctrl.emit_status == ST_SKIPPED) ? (rem_ff + CNT_W'(1)) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff    <= '0;
         rt_ff     <= '0;
         strobe_ff <= 1'b0;
      end else begin
         occ_ff    <= occ_in;
         rt_ff     <= rt_in;
         strobe_ff <= ctrl.emit;
      end
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_status        = status_ff;
   assign rsp_event_handle  = ehnd_ff;
   assign rsp_lateness      = late_ff;
   assign rsp_removed_count = cnt_ff;
   assign rsp_last          = last_ff;

endmodule

`default_nettype wire

/* sv/tequ_ctrl.sv */
// ----------------------------------------------------------------------------
// tequ_ctrl
// Sequencer: takes a command, decodes it and walks the pop loop of an advance.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tequ_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire tequ_pkg::stat_type stat,
   output tequ_pkg::ctrl_type      ctrl
);
   import tequ_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_POP  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       last_pop;

   assign last_pop = !stat.next_due;

   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctrl.load = 1'b1;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
            unique case (stat.op)
               OP_INSERT: begin
                  ctrl.emit      = 1'b1;
                  ctrl.emit_last = 1'b1;
                  if (stat.full) begin
                     ctrl.emit_status = ST_FULL;
                  end else begin
                     ctrl.do_insert   = 1'b1;
                     ctrl.emit_status = ST_INSERTED;
                  end
               end
               OP_ADVANCE: begin
                  ctrl.do_add = 1'b1;
                  state_in    = S_POP;
               end
               OP_CLEAR: begin
                  ctrl.do_clear    = 1'b1;
                  ctrl.emit        = 1'b1;
                  ctrl.emit_status = ST_CLEARED;
                  ctrl.emit_last   = 1'b1;
               end
               default: ;
            endcase
         end
         S_POP: begin
            if (stat.head_due) begin
               ctrl.do_pop    = 1'b1;
               ctrl.emit_last = last_pop;
               if (!stat.skip) begin
                  ctrl.emit        = 1'b1;
                  ctrl.emit_status = ST_DUE;
               end else if (last_pop) begin
                  ctrl.emit        = 1'b1;
                  ctrl.emit_status = ST_SKIPPED;
               end
               if (last_pop) begin
                  state_in = S_IDLE;
               end
            end else begin
               // only reached when nothing at all was due
               ctrl.emit        = 1'b1;
               ctrl.emit_status = ST_NONE;
               ctrl.emit_last   = 1'b1;
               state_in         = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   `ASSERT_NEXT(a_last_ends_item, clock, reset, ctrl.emit && ctrl.emit_last, state_ff == S_IDLE)
   `ASSERT_NEXT(a_accept_to_exec, clock, reset, start && !busy, state_ff == S_EXEC)
   `ASSERT_IMPLY(a_nothing_due, clock, reset, state_ff == S_POP && !stat.head_due, ctrl.emit && ctrl.emit_status == ST_NONE)
   `ASSERT_IMPLY(a_pop_only_in_loop, clock, reset, ctrl.do_pop, state_ff == S_POP && stat.head_due)

endmodule

`default_nettype wire

/* sv/timed_event_queue_unit.sv */
// ----------------------------------------------------------------------------
// timed_event_queue_unit
// Time-sorted queue of operation handles with a running 32-bit time.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Insert, clear, a
// rejected insert and an unused code pass through the execute state once,
// with busy high, and then return to idle. An advance goes on from the
// execute state to the pop state, where the due entries are popped one per
// cycle from the head of the shift-register queue, or a single beat reports
// that none was due. Each result beat appears on the rsp_ ports for exactly
// one cycle with rsp_strobe high, in the cycle after it is produced, and
// cannot be held off; rsp_last marks the final beat of a command. Unused
// operation codes produce no beat at all.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_event_queue_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [tequ_pkg::OP_W-1:0]        req_operation,
   input  wire logic [tequ_pkg::HANDLE_W-1:0]    req_op_handle,
   input  wire logic [tequ_pkg::TIME_W-1:0]      req_time_value,
   input  wire logic                             req_skip,
   output logic                                  rsp_strobe,
   output logic [tequ_pkg::STATUS_W-1:0]         rsp_status,
   output logic [tequ_pkg::HANDLE_W-1:0]         rsp_event_handle,
   output logic [tequ_pkg::TIME_W-1:0]           rsp_lateness,
   output logic [tequ_pkg::CNT_W-1:0]            rsp_removed_count,
   output logic                                  rsp_last
);
   import tequ_pkg::*;

   ctrl_type ctrl;
   stat_type stat;

   tequ_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   tequ_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_operation     (req_operation),
      .req_op_handle     (req_op_handle),
      .req_time_value    (req_time_value),
      .req_skip          (req_skip),
      .ctrl              (ctrl),
      .stat              (stat),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_event_handle  (rsp_event_handle),
      .rsp_lateness      (rsp_lateness),
      .rsp_removed_count (rsp_removed_count),
      .rsp_last          (rsp_last)
   );

endmodule

`default_nettype wire

/* verif/tb_timed_event_queue_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_timed_event_queue_unit
// Self-checking bench for the timed event queue. A queued command stream
// (directed corner cases, then random insert/advance bursts with noise) is
// driven under varying sender gaps; every response beat is compared with a
// behavioural scheduler kept in step with the accepted commands.
// ----------------------------------------------------------------------------

module tb_timed_event_queue_unit;
   import tequ_pkg::*;

   localparam int RANDOM_ITEMS = 340;
   localparam int DRAIN_CYCLES = 2 * MAX_POPS;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [OP_W-1:0]     op;
      logic [HANDLE_W-1:0] handle;
      logic [TIME_W-1:0]   tval;
      logic                skip;
      int unsigned         idle_pct;
   } cmd_type;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [HANDLE_W-1:0] handle;
      logic [TIME_W-1:0]   late;
      logic [CNT_W-1:0]    count;
      logic                last;
   } beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [OP_W-1:0]     req_operation  = '0;
   logic [HANDLE_W-1:0] req_op_handle  = '0;
   logic [TIME_W-1:0]   req_time_value = '0;
   logic                req_skip       = 1'b0;
   logic                rsp_strobe;
   logic [STATUS_W-1:0] rsp_status;
   logic [HANDLE_W-1:0] rsp_event_handle;
   logic [TIME_W-1:0]   rsp_lateness;
   logic [CNT_W-1:0]    rsp_removed_count;
   logic                rsp_last;

   cmd_type  pending_cmds[$];
   beat_type expected_beats[$];
   int unsigned fail_count = 0;

   // scheduler state mirrored from the accepted commands
   logic [TIME_W-1:0]   sched_due[QUEUE_DEPTH];
   logic [HANDLE_W-1:0] sched_hnd[QUEUE_DEPTH];
   int unsigned         sched_occ = 0;
   logic [TIME_W-1:0]   sched_now = '0;

   // stimulus bookkeeping
   logic [TIME_W-1:0] gen_time = '0;
   int unsigned       rand_items = 0;
   int unsigned       phase_idle = 0;

   always #4 clock = ~clock;

   timed_event_queue_unit dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_op_handle     (req_op_handle),
      .req_time_value    (req_time_value),
      .req_skip          (req_skip),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_event_handle  (rsp_event_handle),
      .rsp_lateness      (rsp_lateness),
      .rsp_removed_count (rsp_removed_count),
      .rsp_last          (rsp_last)
   );

   function automatic void expect_beat(logic [STATUS_W-1:0] status,
                                       logic [HANDLE_W-1:0] handle,
                                       logic [TIME_W-1:0] late,
                                       logic [CNT_W-1:0] count,
                                       logic last);
      beat_type b;
      b.status = status;
      b.handle = handle;
      b.late   = late;
      b.count  = count;
      b.last   = last;
      expected_beats.push_back(b);
   endfunction

   // advance the mirrored scheduler by one command and queue its beats
   function automatic void schedule_command(cmd_type c);
      int unsigned pos;
      int unsigned popped;
      beat_type b;
      case (c.op)
         OP_INSERT: begin
            if (sched_occ >= QUEUE_DEPTH) begin
               expect_beat(ST_FULL, '0, '0, '0, 1'b1);
            end else begin
               pos = 0;
               while (pos < sched_occ && c.tval > sched_due[pos])
                  pos++;
               for (int i = sched_occ; i > pos; i--) begin
                  sched_due[i] = sched_due[i-1];
                  sched_hnd[i] = sched_hnd[i-1];
               end
               sched_due[pos] = c.tval;
               sched_hnd[pos] = c.handle;
               sched_occ++;
               expect_beat(ST_INSERTED, '0, '0, '0, 1'b1);
            end
         end
         OP_ADVANCE: begin
            sched_now += c.tval;
            popped = 0;
            while (sched_occ > 0 && popped < MAX_POPS && sched_due[0] <= sched_now) begin
               if (!c.skip)
                  expect_beat(ST_DUE, sched_hnd[0], sched_now - sched_due[0], '0, 1'b0);
               for (int i = 1; i < sched_occ; i++) begin
                  sched_due[i-1] = sched_due[i];
                  sched_hnd[i-1] = sched_hnd[i];
               end
               sched_occ--;
               popped++;
            end
            if (popped == 0) begin
               expect_beat(ST_NONE, '0, '0, '0, 1'b1);
            end else if (c.skip) begin
               expect_beat(ST_SKIPPED, '0, '0, CNT_W'(popped), 1'b1);
            end else begin
               b = expected_beats.pop_back();
               b.last = 1'b1;
               expected_beats.push_back(b);
            end
         end
         OP_CLEAR: begin
            sched_occ = 0;
            sched_now = '0;
            expect_beat(ST_CLEARED, '0, '0, '0, 1'b1);
         end
         default: ;  // unused code: no state change, no beat
      endcase
   endfunction

   task automatic add_cmd(logic [OP_W-1:0] op, logic [HANDLE_W-1:0] handle,
                          logic [TIME_W-1:0] tval, logic skip);
      cmd_type c;
      c.op       = op;
      c.handle   = handle;
      c.tval     = tval;
      c.skip     = skip;
      c.idle_pct = phase_idle;
      pending_cmds.push_back(c);
      if (op == OP_ADVANCE)
         gen_time += tval;
      else if (op == OP_CLEAR)
         gen_time = '0;
      if (op != OP_UNUSED)
         rand_items++;
   endtask

   task automatic add_fill(int unsigned n, int unsigned spread, logic skip);
      for (int i = 0; i < n; i++)
         add_cmd(OP_INSERT, HANDLE_W'($urandom),
                 gen_time + $urandom_range(spread), 1'b0);
      add_cmd(OP_ADVANCE, '0, TIME_W'(spread), skip);
   endtask

   // driver: next command goes out once the current one is taken
   always @(posedge clock) begin
      cmd_type c;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || !busy) begin
         if (pending_cmds.size() != 0 &&
             $urandom_range(99) >= pending_cmds[0].idle_pct) begin
            c = pending_cmds.pop_front();
            req_operation  <= c.op;
            req_op_handle  <= c.handle;
            req_time_value <= c.tval;
            req_skip       <= c.skip;
            start          <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: check response beats, then fold in any accepted command
   always @(posedge clock) begin
      beat_type exp_b;
      cmd_type  seen;
      if (!reset) begin
         if (rsp_strobe) begin
            if (expected_beats.size() == 0) begin
               $display({"%0t: unexpected beat: expected none, ",
                         "actual st=%0d h=%0h late=%0h cnt=%0d last=%0b"},
                        $time, rsp_status, rsp_event_handle, rsp_lateness,
                        rsp_removed_count, rsp_last);
               fail_count++;
            end else begin
               exp_b = expected_beats.pop_front();
               if (rsp_status !== exp_b.status || rsp_event_handle !== exp_b.handle ||
                   rsp_lateness !== exp_b.late || rsp_removed_count !== exp_b.count ||
                   rsp_last !== exp_b.last) begin
                  $display("%0t: beat mismatch: expected st=%0d h=%0h late=%0h cnt=%0d last=%0b",
                           $time, exp_b.status, exp_b.handle, exp_b.late, exp_b.count,
                           exp_b.last);
                  $display("%0t:                actual   st=%0d h=%0h late=%0h cnt=%0d last=%0b",
                           $time, rsp_status, rsp_event_handle, rsp_lateness,
                           rsp_removed_count, rsp_last);
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            seen.op       = req_operation;
            seen.handle   = req_op_handle;
            seen.tval     = req_time_value;
            seen.skip     = req_skip;
            seen.idle_pct = 0;
            schedule_command(seen);
         end
      end
   end

   initial begin
      int unsigned kind;
      int unsigned n;

      // directed corners
      add_cmd(OP_ADVANCE, '0, '0, 1'b0);              // nothing due on empty queue
      add_cmd(OP_INSERT, 16'h0000, 32'h0000_0000, 1'b0);
      add_cmd(OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
      add_cmd(OP_INSERT, 16'h0001, 32'd10, 1'b0);
      add_cmd(OP_INSERT, 16'h0002, 32'd10, 1'b0);      // equal time runs newest first
      add_cmd(OP_INSERT, 16'h0003, 32'd5, 1'b0);
      add_cmd(OP_ADVANCE, '0, 32'd10, 1'b0);
      add_cmd(OP_ADVANCE, '0, 32'd0, 1'b0);
      add_cmd(OP_ADVANCE, '0, 32'hFFFF_FFF5, 1'b0);    // time reaches all-ones
      add_cmd(OP_INSERT, 16'hA5A5, 32'd3, 1'b0);
      add_cmd(OP_ADVANCE, '0, 32'd4, 1'b1);            // wraps, skip summary
      add_cmd(OP_ADVANCE, '0, 32'd7, 1'b1);            // skip with nothing due
      add_cmd(OP_UNUSED, 16'h5A5A, 32'hFFFF_FFFF, 1'b1); // unused code, ignored
      add_cmd(OP_INSERT, 16'h1234, 32'h8000_0000, 1'b1);
      add_cmd(OP_CLEAR, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
      add_cmd(OP_ADVANCE, '0, 32'h7FFF_FFFF, 1'b0);
      add_cmd(OP_CLEAR, '0, '0, 1'b0);

      // random part: full queue and pop limit first, then mixed bursts
      rand_items = 0;
      add_fill(QUEUE_DEPTH + 1, 0, 1'b0);
      add_fill(QUEUE_DEPTH, 50, 1'b1);
      while (rand_items < RANDOM_ITEMS) begin
         case ((rand_items * 4) / RANDOM_ITEMS)
            0:       phase_idle = 0;
            1:       phase_idle = 73;
            2:       phase_idle = 0;
            default: phase_idle = 34;
         endcase
         kind = $urandom_range(99);
         if (kind < 55) begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
               add_cmd(OP_INSERT, HANDLE_W'($urandom),
                       gen_time + 4 * $urandom_range(12), 1'b0);
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
               add_cmd(OP_ADVANCE, HANDLE_W'($urandom), $urandom_range(30),
                       $urandom_range(3) == 0);
         end else if (kind < 63) begin
            add_cmd(OP_ADVANCE, HANDLE_W'($urandom),
                    $urandom_range(1) ? TIME_W'($urandom) : '0, $urandom_range(1));
         end else if (kind < 75) begin
            add_cmd(OP_W'($urandom_range(3)), HANDLE_W'($urandom), TIME_W'($urandom),
                    $urandom_range(1));
         end else if (kind < 80) begin
            add_cmd(OP_CLEAR, HANDLE_W'($urandom), TIME_W'($urandom), $urandom_range(1));
         end else if (kind < 85) begin
            add_fill(QUEUE_DEPTH + $urandom_range(2), $urandom_range(60),
                     $urandom_range(1));
         end else begin
            // run the clock up to the wrap point and schedule across it
            add_cmd(OP_ADVANCE, '0, 32'hFFFF_FFF0 - gen_time - $urandom_range(16), 1'b1);
            for (int i = 0; i < 3; i++)
               add_cmd(OP_INSERT, HANDLE_W'($urandom), gen_time + $urandom_range(40), 1'b0);
            add_cmd(OP_ADVANCE, '0, $urandom_range(30), 1'b0);
            add_cmd(OP_ADVANCE, '0, $urandom_range(30), $urandom_range(1));
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (pending_cmds.size() != 0 || start || expected_beats.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (expected_beats.size() != 0) begin
         $display("%0t: %0d beats never arrived: expected st=%0d h=%0h first, actual none",
                  $time, expected_beats.size(), expected_beats[0].status,
                  expected_beats[0].handle);
         fail_count++;
      end
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("%0t: timeout", $time);
      $display("Test completed with failures");
      $finish;
   end

endmodule
